// File: rtl/core/elg_pkg.sv
`timescale 1ns / 1ps
// Package for the ElGamal encryption block: register indexes, reset values
// and default word width. No dependencies.
package elg_pkg;

    // Default operand width
    localparam int DEFAULT_WORD_BITS = 63;

    // Configuration register index width and indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBKEY    = 2'd2;

    // Register reset values
    localparam int PRIME_RESET     = 23;
    localparam int GENERATOR_RESET = 5;
    localparam int PUBKEY_RESET    = 8;

endpackage

// File: rtl/core/elg_addmod.sv
`timescale 1ns / 1ps
// Modular adder: (x + y) mod p for x, y < p, with one conditional subtract.
// Uses no package items.
module elg_addmod #(
    parameter int WORD_BITS = 63
) (
    input  logic [WORD_BITS-1:0] x,
    input  logic [WORD_BITS-1:0] y,
    input  logic [WORD_BITS-1:0] p,
    output logic [WORD_BITS-1:0] sum
);

    logic [WORD_BITS:0] raw;
    logic [WORD_BITS:0] diff;

    // Full-width add, then fold back once if at or above p
    assign raw  = {1'b0, x} + {1'b0, y};
    assign diff = raw - {1'b0, p};
    assign sum  = (raw >= {1'b0, p}) ? diff[WORD_BITS-1:0] : raw[WORD_BITS-1:0];

endmodule

// File: rtl/core/elg_mulmod.sv
`timescale 1ns / 1ps
// Bit-serial modular multiplier: a * b mod p by double-and-add, MSB first,
// one modular add per cycle on a single elg_addmod. Depends on elg_addmod.
module elg_mulmod #(
    parameter int WORD_BITS = 63
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    input  logic [WORD_BITS-1:0] p,
    output logic                 done,
    output logic [WORD_BITS-1:0] result
);

    localparam int CNT_W = $clog2(WORD_BITS + 1);

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_DBL,
        MM_ADD
    } mm_state_t;

    mm_state_t            state_reg;
    logic [WORD_BITS-1:0] r_reg;
    logic [WORD_BITS-1:0] b_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 done_reg;

    logic [WORD_BITS-1:0] add_y;
    logic [WORD_BITS-1:0] add_sum;

    // Doubling adds r to itself, the add step adds the multiplicand
    assign add_y = (state_reg == MM_ADD) ? a : r_reg;

    elg_addmod #(
        .WORD_BITS (WORD_BITS)
    ) u_add (
        .x   (r_reg),
        .y   (add_y),
        .p   (p),
        .sum (add_sum)
    );

    // Sequencer: one doubling per multiplier bit, an add where the bit is set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            r_reg     <= '0;
            b_reg     <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MM_IDLE:
                begin
                    if (start)
                    begin
                        r_reg     <= '0;
                        b_reg     <= b;
                        cnt_reg   <= CNT_W'(WORD_BITS);
                        state_reg <= MM_DBL;
                    end
                end
                MM_DBL:
                begin
                    r_reg <= add_sum;
                    if (b_reg[WORD_BITS-1])
                    begin
                        state_reg <= MM_ADD;
                    end
                    else
                    begin
                        b_reg   <= b_reg << 1;
                        cnt_reg <= cnt_reg - CNT_W'(1);
                        if (cnt_reg == CNT_W'(1))
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= MM_IDLE;
                        end
                    end
                end
                MM_ADD:
                begin
                    r_reg   <= add_sum;
                    b_reg   <= b_reg << 1;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= MM_IDLE;
                    end
                    else
                    begin
                        state_reg <= MM_DBL;
                    end
                end
                default:
                begin
                    state_reg <= MM_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

// File: rtl/core/elgamal_encrypt_modexp_top.sv
`timescale 1ns / 1ps
// Top level of the ElGamal encryption block: config registers, exponent
// sequencer and output register. Depends on elg_pkg and elg_mulmod.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+----------------------------------------
//  input    | in_valid / in_ready   | plain_value, ephemeral_exponent
//  output   | out_valid / out_ready | cipher_first, cipher_second
//  config   | cfg_we (no wait)      | cfg_index, cfg_data
//
// Every modular multiply runs on the one bit-serial multiplier. A transaction
// is three reductions, then per power one multiply per set bit of k and one
// square per bit below its top set bit, then one final multiply. in_ready is
// high only while idle; a result waits in the output register while the next
// is taken. Reset: p 23, g 5, y 8.
module elgamal_encrypt_modexp_top #(
    parameter int WORD_BITS = elg_pkg::DEFAULT_WORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [WORD_BITS-1:0]          plain_value,
    input  logic [WORD_BITS-1:0]          ephemeral_exponent,
    // output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [WORD_BITS-1:0]          cipher_first,
    output logic [WORD_BITS-1:0]          cipher_second,
    // configuration
    input  logic                          cfg_we,
    input  logic [elg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]          cfg_data
);

    localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDM,
        S_REDB,
        S_CHK,
        S_MUL,
        S_SQR,
        S_FIN,
        S_LOAD
    } seq_state_t;

    // Configuration registers
    logic [WORD_BITS-1:0] p_reg;
    logic [WORD_BITS-1:0] g_reg;
    logic [WORD_BITS-1:0] y_reg;

    // Sequencer state and working registers
    seq_state_t           state_reg;
    logic                 second_reg;
    logic [WORD_BITS-1:0] m_reg;
    logic [WORD_BITS-1:0] k_reg;
    logic [WORD_BITS-1:0] e_reg;
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] sq_reg;
    logic [WORD_BITS-1:0] c1_reg;
    logic                 mm_start_reg;
    logic [WORD_BITS-1:0] op_a_reg;
    logic [WORD_BITS-1:0] op_b_reg;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] cipher_first_reg;
    logic [WORD_BITS-1:0] cipher_second_reg;

    logic                 mm_done;
    logic [WORD_BITS-1:0] mm_result;
    logic                 in_fire;
    logic                 out_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= WORD_BITS'(elg_pkg::PRIME_RESET);
            g_reg <= WORD_BITS'(elg_pkg::GENERATOR_RESET);
            y_reg <= WORD_BITS'(elg_pkg::PUBKEY_RESET);
        end
        else if (cfg_we)
        begin
            if (cfg_index == elg_pkg::CFG_PRIME)
            begin
                p_reg <= cfg_data;
            end
            else if (cfg_index == elg_pkg::CFG_GENERATOR)
            begin
                g_reg <= cfg_data;
            end
            else if (cfg_index == elg_pkg::CFG_PUBKEY)
            begin
                y_reg <= cfg_data;
            end
        end
    end

    // Shared modular multiplier
    elg_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start_reg),
        .a      (op_a_reg),
        .b      (op_b_reg),
        .p      (p_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    // Sequencer: reduce m, then g^k, then y^k, then m * y^k
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            second_reg        <= 1'b0;
            m_reg             <= '0;
            k_reg             <= '0;
            e_reg             <= '0;
            acc_reg           <= '0;
            sq_reg            <= '0;
            c1_reg            <= '0;
            mm_start_reg      <= 1'b0;
            op_a_reg          <= '0;
            op_b_reg          <= '0;
            out_valid_reg     <= 1'b0;
            cipher_first_reg  <= '0;
            cipher_second_reg <= '0;
        end
        else
        begin
            mm_start_reg <= 1'b0;
            if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        k_reg <= ephemeral_exponent;
                        if (p_reg < WORD_BITS'(2))
                        begin
                            // degenerate modulus: both outputs zero
                            c1_reg    <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            mm_start_reg <= 1'b1;
                            op_a_reg     <= ONE;
                            op_b_reg     <= plain_value;
                            state_reg    <= S_REDM;
                        end
                    end
                end
                S_REDM:
                begin
                    if (mm_done)
                    begin
                        m_reg        <= mm_result;
                        second_reg   <= 1'b0;
                        mm_start_reg <= 1'b1;
                        op_a_reg     <= ONE;
                        op_b_reg     <= g_reg;
                        state_reg    <= S_REDB;
                    end
                end
                S_REDB:
                begin
                    // base reduced: start a power
                    if (mm_done)
                    begin
                        sq_reg    <= mm_result;
                        acc_reg   <= ONE;
                        e_reg     <= k_reg;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    mm_start_reg <= 1'b1;
                    if (e_reg == '0)
                    begin
                        if (!second_reg)
                        begin
                            c1_reg     <= acc_reg;
                            second_reg <= 1'b1;
                            op_a_reg   <= ONE;
                            op_b_reg   <= y_reg;
                            state_reg  <= S_REDB;
                        end
                        else
                        begin
                            op_a_reg  <= m_reg;
                            op_b_reg  <= acc_reg;
                            state_reg <= S_FIN;
                        end
                    end
                    else if (e_reg[0])
                    begin
                        op_a_reg  <= acc_reg;
                        op_b_reg  <= sq_reg;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        op_a_reg  <= sq_reg;
                        op_b_reg  <= sq_reg;
                        state_reg <= S_SQR;
                    end
                end
                S_MUL:
                begin
                    if (mm_done)
                    begin
                        acc_reg <= mm_result;
                        if ((e_reg >> 1) == '0)
                        begin
                            // top bit done, no further square needed
                            e_reg     <= '0;
                            state_reg <= S_CHK;
                        end
                        else
                        begin
                            mm_start_reg <= 1'b1;
                            op_a_reg     <= sq_reg;
                            op_b_reg     <= sq_reg;
                            state_reg    <= S_SQR;
                        end
                    end
                end
                S_SQR:
                begin
                    if (mm_done)
                    begin
                        sq_reg    <= mm_result;
                        e_reg     <= e_reg >> 1;
                        state_reg <= S_CHK;
                    end
                end
                S_FIN:
                begin
                    if (mm_done)
                    begin
                        acc_reg   <= mm_result;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    // wait for the output register to free up
                    if (!out_valid_reg || out_ready)
                    begin
                        cipher_first_reg  <= c1_reg;
                        cipher_second_reg <= acc_reg;
                        out_valid_reg     <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign cipher_first  = cipher_first_reg;
    assign cipher_second = cipher_second_reg;

endmodule

// File: rtl/core/elg_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the ElGamal encryption block, bound to the top level.
// Depends on elg_pkg and elgamal_encrypt_modexp_top.
module elg_checker #(
    parameter int WORD_BITS = elg_pkg::DEFAULT_WORD_BITS
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [WORD_BITS-1:0] cipher_first,
    input logic [WORD_BITS-1:0] cipher_second
);

    // One transaction at a time: ready drops once an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready still high after input transaction");

    // A pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(cipher_first) && $stable(cipher_second)))
        else $error("output transaction dropped or changed while stalled");

    // A new result appears exactly when the sequencer goes idle
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result shown while sequencer still busy");

    // ... and was produced while the input side was closed
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a computation");

endmodule

bind elgamal_encrypt_modexp_top elg_checker #(
    .WORD_BITS (WORD_BITS)
) u_elg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cipher_first  (cipher_first),
    .cipher_second (cipher_second)
);

// File: tb/tb_elgamal_encrypt_modexp_top.sv
`timescale 1ns / 1ps
// Testbench for elgamal_encrypt_modexp_top: directed and random encryption
// transactions checked against an in-bench modular arithmetic predictor.
// Depends on elg_pkg and the RTL of the block.
module tb_elgamal_encrypt_modexp_top;

    localparam int W              = elg_pkg::DEFAULT_WORD_BITS;
    localparam int WATCHDOG_LIMIT = 250000;
    localparam int SETTLE_CYCLES  = 20;

    typedef logic [W-1:0] word_t;

    typedef struct packed {
        word_t c1;
        word_t c2;
    } cipher_t;

    localparam word_t WORD_MAX     = '1;
    localparam word_t LARGEST_PRIME = 63'd9223372036854775783;

    // DUT connections, all inputs known from time zero
    logic                          clk                = 1'b0;
    logic                          rst_n              = 1'b0;
    logic                          in_valid           = 1'b0;
    logic                          in_ready;
    word_t                         plain_value        = '0;
    word_t                         ephemeral_exponent = '0;
    logic                          out_valid;
    logic                          out_ready          = 1'b0;
    word_t                         cipher_first;
    word_t                         cipher_second;
    logic                          cfg_we             = 1'b0;
    logic [elg_pkg::CFG_IDX_W-1:0] cfg_index          = elg_pkg::CFG_PRIME;
    word_t                         cfg_data           = '0;

    // shadow of the key registers, as after reset
    word_t cur_modulus   = word_t'(elg_pkg::PRIME_RESET);
    word_t cur_generator = word_t'(elg_pkg::GENERATOR_RESET);
    word_t cur_pubkey    = word_t'(elg_pkg::PUBKEY_RESET);

    cipher_t cipher_pending_q[$];
    int      error_count    = 0;
    int      stall_cycles   = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;

    elgamal_encrypt_modexp_top #(
        .WORD_BITS(W)
    ) uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .plain_value        (plain_value),
        .ephemeral_exponent (ephemeral_exponent),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .cipher_first       (cipher_first),
        .cipher_second      (cipher_second),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: full double-width products reduced mod p
    // ------------------------------------------------------------------
    function automatic word_t mod_mul(input word_t a, input word_t b, input word_t p);
        logic [2*W-1:0] prod;
        logic [2*W-1:0] rem;
        prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
        rem  = prod % {{W{1'b0}}, p};
        return rem[W-1:0];
    endfunction

    // right-to-left square-and-multiply, p at least 2
    function automatic word_t mod_pow(input word_t base, input word_t e, input word_t p);
        word_t acc;
        word_t sq;
        acc = word_t'(1);
        sq  = base % p;
        for (int i = 0; i < W; i++)
        begin
            if (e[i])
                acc = mod_mul(acc, sq, p);
            sq = mod_mul(sq, sq, p);
        end
        return acc;
    endfunction

    function automatic cipher_t encrypt_predict(input word_t msg, input word_t k);
        cipher_t c;
        c = '0;
        // modulus zero or one gives an all-zero ciphertext
        if (cur_modulus >= word_t'(2))
        begin
            c.c1 = mod_pow(cur_generator, k, cur_modulus);
            c.c2 = mod_mul(msg % cur_modulus, mod_pow(cur_pubkey, k, cur_modulus),
                           cur_modulus);
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    function automatic word_t rand_word();
        return word_t'({$urandom, $urandom});
    endfunction

    function automatic word_t rand_bits(input int n);
        word_t v;
        v = rand_word();
        if (n < W)
            v = v & ((word_t'(1) << n) - word_t'(1));
        return v;
    endfunction

    // mostly short exponents keep the run length sensible; a few full width
    function automatic word_t rand_exponent();
        if ($urandom_range(9) == 0)
            return rand_word();
        return rand_bits($urandom_range(10, 1));
    endfunction

    // ------------------------------------------------------------------
    // Reporting, driving and waiting
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // present one transaction, wait for acceptance, record its expectation
    task automatic send_item(input word_t msg, input word_t k);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid           <= 1'b1;
        plain_value        <= msg;
        ephemeral_exponent <= k;
        do
            @(posedge clk);
        while (!in_ready);
        cipher_pending_q.push_back(encrypt_predict(msg, k));
    endtask

    // stop sending and wait until every expected result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        while (cipher_pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [elg_pkg::CFG_IDX_W-1:0] idx, input word_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            elg_pkg::CFG_PRIME:     cur_modulus   = value;
            elg_pkg::CFG_GENERATOR: cur_generator = value;
            elg_pkg::CFG_PUBKEY:    cur_pubkey    = value;
            default: ;
        endcase
    endtask

    task automatic set_keys(input word_t p, input word_t g, input word_t y);
        drain_results();
        write_reg(elg_pkg::CFG_PRIME, p);
        write_reg(elg_pkg::CFG_GENERATOR, g);
        write_reg(elg_pkg::CFG_PUBKEY, y);
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        cipher_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (cipher_pending_q.size() == 0)
                    report_error($sformatf("unexpected result c1=%h c2=%h",
                                           cipher_first, cipher_second));
                else
                begin
                    want = cipher_pending_q.pop_front();
                    if (cipher_first !== want.c1)
                        report_error($sformatf("cipher_first %h, expected %h",
                                               cipher_first, want.c1));
                    if (cipher_second !== want.c2)
                        report_error($sformatf("cipher_second %h, expected %h",
                                               cipher_second, want.c2));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // keys as left by reset: p = 23, g = 5, y = 8
    task automatic test_reset_settings();
        send_item('0, '0);              // zero exponent: c1 = 1, c2 = m
        send_item(word_t'(22), word_t'(1));
        send_item(word_t'(23), word_t'(22));   // message equal to p
        send_item(WORD_MAX, WORD_MAX);
    endtask

    // degenerate and tiny moduli
    task automatic test_small_moduli();
        set_keys('0, word_t'(5), word_t'(8));      // all-zero result
        send_item(word_t'(7), word_t'(3));
        send_item(WORD_MAX, '0);
        set_keys(word_t'(1), word_t'(5), word_t'(8)); // still all zero
        send_item(word_t'(1), word_t'(1));
        set_keys(word_t'(2), word_t'(3), '0);       // modulus two, zero key
        send_item(word_t'(1), word_t'(5));
        send_item(word_t'(3), '0);
        set_keys(word_t'(3), word_t'(2), word_t'(2));
        send_item(word_t'(2), word_t'(2));
        send_item(word_t'(4), word_t'(3));
        set_keys(word_t'(9), word_t'(6), word_t'(4)); // composite modulus
        send_item(word_t'(8), word_t'(7));
    endtask

    // full-width moduli, some with bases at or above p
    task automatic test_wide_moduli();
        set_keys(LARGEST_PRIME, WORD_MAX, LARGEST_PRIME);
        send_item(WORD_MAX, WORD_MAX);
        send_item(LARGEST_PRIME, word_t'(1));
        send_item('0, '0);
        set_keys(WORD_MAX, '0, WORD_MAX - word_t'(1));
        send_item(WORD_MAX - word_t'(1), '0);       // zero base, zero exponent
        send_item(WORD_MAX, word_t'(1) << (W - 1));
        send_item(rand_word(), word_t'(12345));
    endtask

    // random keys and messages under each idling pattern
    task automatic test_random_traffic();
        word_t p;
        word_t g;
        word_t y;
        for (int phase = 0; phase < 7; phase++)
        begin
            case ($urandom_range(7))
                0:       p = word_t'($urandom_range(3));
                1:       p = rand_word();
                2:       p = LARGEST_PRIME;
                default: p = rand_bits($urandom_range(62, 2));
            endcase
            g = ($urandom_range(1) != 0) ? rand_word() : rand_bits($urandom_range(20, 1));
            y = ($urandom_range(1) != 0) ? rand_word() : rand_bits($urandom_range(20, 1));
            set_keys(p, g, y);
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase
            for (int n = 0; n < 18; n++)
            begin
                if ($urandom_range(5) == 0)
                    send_item(rand_bits($urandom_range(8, 1)), rand_exponent());
                else
                    send_item(rand_word(), rand_exponent());
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_small_moduli();
        test_wide_moduli();
        test_random_traffic();

        drain_results();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
